// File: hdl/stmc_pkg.sv
package stmc_pkg;

  localparam int DEF_MAP_ROWS    = 64;
  localparam int DEF_MAP_COLS    = 64;
  localparam int DEF_SCREEN_ROWS = 32;
  localparam int DEF_SCREEN_COLS = 32;

  localparam int OP_W     = 2;
  localparam int CELL_W   = 6;
  localparam int TILE_W   = 16;
  localparam int SIZE_W   = 7;
  localparam int VEL_W    = 5;
  localparam int SCROLL_W = 16;
  localparam int SETCNT_W = 2;
  localparam int COLS_W   = 8;
  localparam int DEST_W   = 13;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared divider: 16-bit dividend, 8-bit divisor, 4 quotient bits per cycle
  localparam int DIV_W      = 16;
  localparam int DIVISOR_W  = 8;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam logic [SIZE_W-1:0]   RST_TILE_SIZE = 7'd16;
  localparam logic [SETCNT_W-1:0] RST_SET_COUNT = 2'd1;
  localparam logic [TILE_W-1:0]   RST_FIRST_ID  = 16'd1;
  localparam logic [COLS_W-1:0]   RST_COLUMNS   = 8'd1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_DRAW  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE   = 3'd0,
    CFG_VELOCITY_X  = 3'd1,
    CFG_VELOCITY_Y  = 3'd2,
    CFG_SET_COUNT   = 3'd3,
    CFG_FIRST_ID_A  = 3'd4,
    CFG_COLUMNS_A   = 3'd5,
    CFG_FIRST_ID_B  = 3'd6,
    CFG_COLUMNS_B   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_SEL_X  = 2'd0,
    DIV_SEL_Y  = 2'd1,
    DIV_SEL_ID = 2'd2
  } div_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XS,
    S_XW,
    S_YW,
    S_RD,
    S_LK,
    S_IW,
    S_EM
  } state_t;

  typedef struct packed {
    logic     take_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_x;
    logic     cap_y;
    logic     ram_re;
    logic     cap_lookup;
    logic     cap_src;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            div_done;
    logic            need_div;
    logic            can_load;
  } status_t;

endpackage

// File: hdl/stmc_if.sv
interface stmc_in_if;
  import stmc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [CELL_W-1:0]   row_index;
  logic [CELL_W-1:0]   column_index;
  logic [TILE_W-1:0]   tile_value;

  modport source (output valid, opcode, row_index, column_index, tile_value, input ready);
  modport sink   (input valid, opcode, row_index, column_index, tile_value, output ready);
endinterface

interface stmc_out_if;
  import stmc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     tile_present;
  logic                     out_of_range;
  logic                     set_index;
  logic [DIV_W-1:0]         source_row;
  logic [COLS_W-1:0]        source_column;
  logic signed [DEST_W-1:0] dest_x;
  logic signed [DEST_W-1:0] dest_y;

  modport source (output valid, tile_present, out_of_range, set_index, source_row,
                  source_column, dest_x, dest_y, input ready);
  modport sink   (input valid, tile_present, out_of_range, set_index, source_row,
                  source_column, dest_x, dest_y, output ready);
endinterface

// File: hdl/stmc_ram.sv
module stmc_ram #(
  parameter int WIDTH = stmc_pkg::TILE_W,
  parameter int DEPTH = stmc_pkg::DEF_MAP_ROWS * stmc_pkg::DEF_MAP_COLS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/stmc_divider.sv
module stmc_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [stmc_pkg::DIV_W-1:0]     dividend,
  input  logic [stmc_pkg::DIVISOR_W-1:0] divisor,
  output logic                           done,
  output logic [stmc_pkg::DIV_W-1:0]     quotient,
  output logic [stmc_pkg::DIVISOR_W-1:0] remainder
);
  import stmc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r;

  // restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    logic [DIVISOR_W:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial   = {rem_nxt, quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = DIVISOR_W'(trial - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == CNT_LAST) |=> (done_r && !busy_r))
    else $error("divider did not finish after last step");
`endif

endmodule

// File: hdl/stmc_datapath.sv
module stmc_datapath #(
  parameter int MAP_ROWS    = stmc_pkg::DEF_MAP_ROWS,
  parameter int MAP_COLS    = stmc_pkg::DEF_MAP_COLS,
  parameter int SCREEN_ROWS = stmc_pkg::DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = stmc_pkg::DEF_SCREEN_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [stmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [stmc_pkg::OP_W-1:0]       in_opcode,
  input  logic [stmc_pkg::CELL_W-1:0]     in_row_index,
  input  logic [stmc_pkg::CELL_W-1:0]     in_column_index,
  input  logic [stmc_pkg::TILE_W-1:0]     in_tile_value,
  input  stmc_pkg::cmd_t                  cmd,
  output stmc_pkg::status_t               status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_tile_present,
  output logic                            out_out_of_range,
  output logic                            out_set_index,
  output logic [stmc_pkg::DIV_W-1:0]      out_source_row,
  output logic [stmc_pkg::COLS_W-1:0]     out_source_column,
  output logic [stmc_pkg::DEST_W-1:0]     out_dest_x,
  output logic [stmc_pkg::DEST_W-1:0]     out_dest_y
);
  import stmc_pkg::*;

  localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // configuration
  logic [SIZE_W-1:0]   tile_size_r;
  logic [VEL_W-1:0]    vel_x_r, vel_y_r;
  logic [SETCNT_W-1:0] set_count_r;
  logic [TILE_W-1:0]   first_a_r, first_b_r;
  logic [COLS_W-1:0]   cols_a_r, cols_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= RST_TILE_SIZE;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      set_count_r <= RST_SET_COUNT;
      first_a_r   <= RST_FIRST_ID;
      cols_a_r    <= RST_COLUMNS;
      first_b_r   <= RST_FIRST_ID;
      cols_b_r    <= RST_COLUMNS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TILE_SIZE:  tile_size_r <= cfg_data[SIZE_W-1:0];
        CFG_VELOCITY_X: vel_x_r     <= cfg_data[VEL_W-1:0];
        CFG_VELOCITY_Y: vel_y_r     <= cfg_data[VEL_W-1:0];
        CFG_SET_COUNT:  set_count_r <= cfg_data[SETCNT_W-1:0];
        CFG_FIRST_ID_A: first_a_r   <= cfg_data[TILE_W-1:0];
        CFG_COLUMNS_A:  cols_a_r    <= cfg_data[COLS_W-1:0];
        CFG_FIRST_ID_B: first_b_r   <= cfg_data[TILE_W-1:0];
        CFG_COLUMNS_B:  cols_b_r    <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] size_eff;
  assign size_eff = (tile_size_r == '0) ? SIZE_W'(1) : tile_size_r;

  // scroll position and item capture
  logic [SCROLL_W-1:0] scroll_x_r, scroll_y_r;
  logic [CELL_W-1:0]   row_r, col_r;
  logic                is_write, is_tick;

  assign is_write = cmd.take_item && (in_opcode == OP_WRITE);
  assign is_tick  = cmd.take_item && (in_opcode == OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r <= '0;
      scroll_y_r <= '0;
    end else if (is_tick) begin
      scroll_x_r <= scroll_x_r + {{(SCROLL_W-VEL_W){vel_x_r[VEL_W-1]}}, vel_x_r};
      scroll_y_r <= scroll_y_r + {{(SCROLL_W-VEL_W){vel_y_r[VEL_W-1]}}, vel_y_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      row_r <= in_row_index;
      col_r <= in_column_index;
    end
  end

  // shared divider
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic [DIVISOR_W-1:0] div_rem;
  logic [TILE_W-1:0]    sheet_off;
  logic [COLS_W-1:0]    sheet_cols;

  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_X: begin
        div_dividend = scroll_x_r[SCROLL_W-1] ? (DIV_W'(0) - scroll_x_r) : scroll_x_r;
        div_divisor  = {1'b0, size_eff};
      end
      DIV_SEL_Y: begin
        div_dividend = scroll_y_r[SCROLL_W-1] ? (DIV_W'(0) - scroll_y_r) : scroll_y_r;
        div_divisor  = {1'b0, size_eff};
      end
      DIV_SEL_ID: begin
        div_dividend = sheet_off;
        div_divisor  = sheet_cols;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIVISOR_W'(1);
      end
    endcase
  end

  stmc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // signed tile offset and pixel remainder, truncated toward zero
  logic [DIV_W:0]    offx_r, offy_r;
  logic [COLS_W-1:0] remx_r, remy_r;
  logic [DIV_W:0]    q_ext;
  logic [COLS_W-1:0] r_ext;

  assign q_ext = {1'b0, div_quo};
  assign r_ext = {1'b0, div_rem[SIZE_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      offx_r <= scroll_x_r[SCROLL_W-1] ? ((DIV_W+1)'(0) - q_ext) : q_ext;
      remx_r <= scroll_x_r[SCROLL_W-1] ? (COLS_W'(0) - r_ext) : r_ext;
    end
    if (cmd.cap_y) begin
      offy_r <= scroll_y_r[SCROLL_W-1] ? ((DIV_W+1)'(0) - q_ext) : q_ext;
      remy_r <= scroll_y_r[SCROLL_W-1] ? (COLS_W'(0) - r_ext) : r_ext;
    end
  end

  // map cell of the draw
  logic [DIV_W+1:0] map_r, map_c;
  logic             screen_oor, map_oor;

  assign map_r = {{(DIV_W+2-CELL_W){1'b0}}, row_r} + {offy_r[DIV_W], offy_r};
  assign map_c = {{(DIV_W+2-CELL_W){1'b0}}, col_r} + {offx_r[DIV_W], offx_r};

  assign screen_oor = ({1'b0, row_r} >= (CELL_W+1)'(SCREEN_ROWS)) ||
                      ({1'b0, col_r} >= (CELL_W+1)'(SCREEN_COLS));
  assign map_oor    = map_r[DIV_W+1] || (map_r[DIV_W:0] >= (DIV_W+1)'(MAP_ROWS)) ||
                      map_c[DIV_W+1] || (map_c[DIV_W:0] >= (DIV_W+1)'(MAP_COLS));

  // linear map addresses; indexes are below 512 when in range
  logic [17:0]       rd_lin, wr_lin;
  logic [MAP_AW-1:0] rd_addr, wr_addr;
  logic              wr_in_map;

  assign rd_lin  = {9'b0, map_r[8:0]} * 18'(MAP_COLS) + {9'b0, map_c[8:0]};
  assign wr_lin  = {12'b0, in_row_index} * 18'(MAP_COLS) + {12'b0, in_column_index};
  assign rd_addr = rd_lin[MAP_AW-1:0];
  assign wr_addr = wr_lin[MAP_AW-1:0];
  assign wr_in_map = ({3'b0, in_row_index} < 9'(MAP_ROWS)) &&
                     ({3'b0, in_column_index} < 9'(MAP_COLS));

  logic [TILE_W-1:0] tile_id;

  stmc_ram #(
    .WIDTH (TILE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (is_write && wr_in_map),
    .waddr (wr_addr),
    .wdata (in_tile_value),
    .re    (cmd.ram_re),
    .raddr (rd_addr),
    .rdata (tile_id)
  );

  // tileset choice on the fetched id
  logic              id_empty, pick_b, id_bad, blocked, need_div;
  logic [TILE_W-1:0] first_sel;

  assign id_empty   = (tile_id == '0);
  assign pick_b     = set_count_r[1] && !((tile_id >= first_a_r) && (tile_id < first_b_r));
  assign first_sel  = pick_b ? first_b_r : first_a_r;
  assign sheet_cols = pick_b ? cols_b_r : cols_a_r;
  assign id_bad     = (tile_id < first_sel) || (sheet_cols == '0);
  assign sheet_off  = tile_id - first_sel;
  assign blocked    = screen_oor || map_oor;
  assign need_div   = !blocked && !id_empty && !id_bad;

  logic              res_present_r, res_oor_r, res_set_r;
  logic [DIV_W-1:0]  src_row_r;
  logic [COLS_W-1:0] src_col_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_lookup) begin
      res_present_r <= need_div;
      res_oor_r     <= blocked || (!id_empty && id_bad);
      res_set_r     <= !blocked && !id_empty && pick_b;
      src_row_r     <= '0;
      src_col_r     <= '0;
    end else if (cmd.cap_src) begin
      src_row_r <= div_quo;
      src_col_r <= div_rem;
    end
  end

  // destination pixel, wraps to 13 bits
  logic [DEST_W-1:0] prod_x, prod_y, dest_x, dest_y;

  assign prod_x = DEST_W'({7'b0, col_r} * {6'b0, size_eff});
  assign prod_y = DEST_W'({7'b0, row_r} * {6'b0, size_eff});
  assign dest_x = screen_oor ? '0 :
                  prod_x - {{(DEST_W-COLS_W){remx_r[COLS_W-1]}}, remx_r};
  assign dest_y = screen_oor ? '0 :
                  prod_y - {{(DEST_W-COLS_W){remy_r[COLS_W-1]}}, remy_r};

  // output register
  logic              out_valid_r;
  logic              out_present_r, out_oor_r, out_set_r;
  logic [DIV_W-1:0]  out_row_r;
  logic [COLS_W-1:0] out_col_r;
  logic [DEST_W-1:0] out_dx_r, out_dy_r;
  logic              can_load;

  assign can_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_present_r <= res_present_r;
      out_oor_r     <= res_oor_r;
      out_set_r     <= res_set_r;
      out_row_r     <= src_row_r;
      out_col_r     <= src_col_r;
      out_dx_r      <= dest_x;
      out_dy_r      <= dest_y;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tile_present  = out_present_r;
  assign out_out_of_range  = out_oor_r;
  assign out_set_index     = out_set_r;
  assign out_source_row    = out_row_r;
  assign out_source_column = out_col_r;
  assign out_dest_x        = out_dx_r;
  assign out_dest_y        = out_dy_r;

  assign status.in_op    = in_opcode;
  assign status.div_done = div_done;
  assign status.need_div = need_div;
  assign status.can_load = can_load;

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over one not yet taken");

  a_present_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_present_r && out_oor_r))
    else $error("tile flagged present and out of range");

  a_src_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_src |-> div_done)
    else $error("sheet position captured before divider finished");
`endif

endmodule

// File: hdl/stmc_ctrl.sv
module stmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stmc_pkg::status_t status,
  output stmc_pkg::cmd_t    cmd
);
  import stmc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && status.in_op == OP_DRAW) state_nxt = S_XS;
      S_XS:   state_nxt = S_XW;
      S_XW:   if (status.div_done) state_nxt = S_YW;
      S_YW:   if (status.div_done) state_nxt = S_RD;
      S_RD:   state_nxt = S_LK;
      S_LK:   state_nxt = status.need_div ? S_IW : S_EM;
      S_IW:   if (status.div_done) state_nxt = S_EM;
      S_EM:   if (status.can_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_SEL_X;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      S_XS: begin
        cmd.div_start = 1'b1;
      end
      S_XW: begin
        // chain the vertical division straight after the horizontal one
        if (status.div_done) begin
          cmd.cap_x     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_Y;
        end
      end
      S_YW: begin
        cmd.cap_y = status.div_done;
      end
      S_RD: begin
        cmd.ram_re = 1'b1;
      end
      S_LK: begin
        cmd.cap_lookup = 1'b1;
        cmd.div_sel    = DIV_SEL_ID;
        cmd.div_start  = status.need_div;
      end
      S_IW: begin
        cmd.cap_src = status.div_done;
      end
      S_EM: begin
        cmd.load_out = status.can_load;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/scrolling_tile_map_cell_fetch.sv
// map write and scroll tick: no result, next item the cycle after
// draw: result after the x and y offset divisions, map read and lookup, and the sheet
// division when the id needs one; no item is taken until it is loaded; the shared divider
// (4 quotient bits a cycle) runs the x and y offset and sheet position divisions in turn
// a waiting result does not stop writes and ticks; it holds only the final load
// rst_n is synchronous: clears control, scroll and config to defaults; map is not cleared
module scrolling_tile_map_cell_fetch #(
  parameter int MAP_ROWS    = stmc_pkg::DEF_MAP_ROWS,
  parameter int MAP_COLS    = stmc_pkg::DEF_MAP_COLS,
  parameter int SCREEN_ROWS = stmc_pkg::DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = stmc_pkg::DEF_SCREEN_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  stmc_in_if.sink                         in_chan,
  stmc_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [stmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stmc_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic              in_ready;
  logic              out_valid;
  logic              out_tile_present, out_out_of_range, out_set_index;
  logic [DIV_W-1:0]  out_source_row;
  logic [COLS_W-1:0] out_source_column;
  logic [DEST_W-1:0] out_dest_x, out_dest_y;

  stmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  stmc_datapath #(
    .MAP_ROWS    (MAP_ROWS),
    .MAP_COLS    (MAP_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_opcode         (in_chan.opcode),
    .in_row_index      (in_chan.row_index),
    .in_column_index   (in_chan.column_index),
    .in_tile_value     (in_chan.tile_value),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (out_chan.ready),
    .out_valid         (out_valid),
    .out_tile_present  (out_tile_present),
    .out_out_of_range  (out_out_of_range),
    .out_set_index     (out_set_index),
    .out_source_row    (out_source_row),
    .out_source_column (out_source_column),
    .out_dest_x        (out_dest_x),
    .out_dest_y        (out_dest_y)
  );

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid;
  assign out_chan.tile_present  = out_tile_present;
  assign out_chan.out_of_range  = out_out_of_range;
  assign out_chan.set_index     = out_set_index;
  assign out_chan.source_row    = out_source_row;
  assign out_chan.source_column = out_source_column;
  assign out_chan.dest_x        = out_dest_x;
  assign out_chan.dest_y        = out_dest_y;

endmodule
